// ===== rtl/core/frsr_pkg.sv =====
// frsr_pkg: shared types, widths and codes for the flow remaining-size ranker
// used by frsr_cam, frsr_count_mem, frsr_update and the top level
`default_nettype none

package frsr_pkg;

  localparam int FLOWS_DEF    = 64;
  localparam int KEY_BITS_DEF = 32;
  localparam int IN_KEY_W     = 32;
  localparam int LEN_W        = 16;
  localparam int COUNT_W      = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic OP_LEARN = 1'b0;
  localparam logic OP_RANK  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // lookup outcome carried from the table stage to the update stage
  typedef struct packed {
    logic valid;
    logic op;
    logic hit;
    logic insert;
  } lookup_t;

endpackage

`default_nettype wire

// ===== rtl/core/frsr_cam.sv =====
// frsr_cam: associative key store with valid bits and fill count
// depends on frsr_pkg; slots fill in order since entries are never freed
`default_nettype none

module frsr_cam #(
  parameter int FLOWS    = frsr_pkg::FLOWS_DEF,
  parameter int KEY_BITS = frsr_pkg::KEY_BITS_DEF,
  localparam int SLOT_W  = (FLOWS > 1) ? $clog2(FLOWS) : 1,
  localparam int FILL_W  = $clog2(FLOWS + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                lookup_en,
  input  wire logic                op,
  input  wire logic [KEY_BITS-1:0] key,
  output logic                     hit,
  output logic                     insert,
  output logic [SLOT_W-1:0]        slot
);

  logic [KEY_BITS-1:0] keys [FLOWS];
  logic [FLOWS-1:0]    valid;
  logic [FILL_W-1:0]   fill;
  logic [FLOWS-1:0]    match;
  logic [SLOT_W-1:0]   match_idx;
  logic                full;

  // keys are unique, so the match vector is at most one-hot
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < FLOWS; i++) begin
      match[i] = valid[i] && (keys[i] == key);
      if (match[i]) begin
        match_idx = match_idx | SLOT_W'(i);
      end
    end
  end

  assign hit    = |match;
  assign full   = (fill == FILL_W'(FLOWS));
  assign insert = lookup_en && (op == frsr_pkg::OP_LEARN) && !hit && !full;
  assign slot   = hit ? match_idx : fill[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      fill  <= '0;
    end else if (insert) begin
      valid[fill[SLOT_W-1:0]] <= 1'b1;
      fill                    <= fill + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (insert) begin
      keys[fill[SLOT_W-1:0]] <= key;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/frsr_count_mem.sv =====
// frsr_count_mem: per-slot remaining byte counts, one write and one read port
// depends on frsr_pkg for the count width; read data is registered
`default_nettype none

module frsr_count_mem #(
  parameter int FLOWS   = frsr_pkg::FLOWS_DEF,
  localparam int SLOT_W = (FLOWS > 1) ? $clog2(FLOWS) : 1
) (
  input  wire logic                         clk,
  input  wire logic [SLOT_W-1:0]            rd_addr,
  output logic      [frsr_pkg::COUNT_W-1:0] rd_data,
  input  wire logic                         wr_en,
  input  wire logic [SLOT_W-1:0]            wr_addr,
  input  wire logic [frsr_pkg::COUNT_W-1:0] wr_data
);

  logic [frsr_pkg::COUNT_W-1:0] mem [FLOWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/frsr_update.sv =====
// frsr_update: count update and result selection for one item
// depends on frsr_pkg for codes, widths and the lookup struct
`default_nettype none

module frsr_update (
  input  wire frsr_pkg::lookup_t              ctl,
  input  wire logic [frsr_pkg::LEN_W-1:0]     len,
  input  wire logic [frsr_pkg::COUNT_W-1:0]   cur,
  output logic                                we,
  output logic      [frsr_pkg::COUNT_W-1:0]   new_count,
  output logic      [frsr_pkg::COUNT_W-1:0]   prio,
  output frsr_pkg::status_t                   status
);

  logic [frsr_pkg::COUNT_W:0]   sum;
  logic [frsr_pkg::COUNT_W-1:0] len_ext;

  assign len_ext = frsr_pkg::COUNT_W'(len);
  assign sum     = {1'b0, cur} + {1'b0, len_ext};

  always_comb begin
    we        = 1'b0;
    new_count = cur;
    prio      = '0;
    status    = frsr_pkg::ST_OK;
    if (ctl.op == frsr_pkg::OP_LEARN) begin
      if (ctl.hit) begin
        we        = ctl.valid;
        new_count = sum[frsr_pkg::COUNT_W] ? frsr_pkg::COUNT_MAX
                                            : sum[frsr_pkg::COUNT_W-1:0];
      end else if (ctl.insert) begin
        we        = ctl.valid;
        new_count = len_ext;
      end else begin
        status = frsr_pkg::ST_FULL;
      end
    end else begin
      if (!ctl.hit) begin
        status = frsr_pkg::ST_UNKNOWN;
      end else if (cur == '0) begin
        status = frsr_pkg::ST_EMPTY;
      end else begin
        we        = ctl.valid;
        prio      = cur;
        new_count = (cur > len_ext) ? (cur - len_ext) : '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/flow_remaining_size_ranker_unit.sv =====
// flow_remaining_size_ranker_unit: per-flow byte table giving remaining-size ranks
// done is registered after s1_valid and s2_ctl; one item accepted every cycle
// throughput is set by the count memory: one read and one write per cycle, with bypass
// busy is never raised, and done/results are shown for exactly one cycle
// reset (rst, synchronous) clears all valid bits and the fill count at once
// depends on frsr_pkg, frsr_cam, frsr_count_mem and frsr_update
`default_nettype none

module flow_remaining_size_ranker_unit #(
  parameter int FLOWS    = frsr_pkg::FLOWS_DEF,
  parameter int KEY_BITS = frsr_pkg::KEY_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          op,
  input  wire logic [frsr_pkg::IN_KEY_W-1:0] flow_key,
  input  wire logic [frsr_pkg::LEN_W-1:0]    pkt_len,
  output logic                               done,
  output logic      [frsr_pkg::COUNT_W-1:0]  priority_res,
  output logic      [1:0]                    status
);

  localparam int SLOT_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;

  // the table updates keys in the lookup stage and counts in the update
  // stage, so nothing ever has to stall
  assign busy = 1'b0;

  // key as stored: low KEY_BITS bits of the port, zero-extended when wider
  logic [KEY_BITS-1:0] key_in;
  if (KEY_BITS <= frsr_pkg::IN_KEY_W) begin : g_key_trunc
    assign key_in = flow_key[KEY_BITS-1:0];
  end else begin : g_key_ext
    assign key_in = {{(KEY_BITS - frsr_pkg::IN_KEY_W){1'b0}}, flow_key};
  end

  // lookup stage: input register
  logic                         s1_valid;
  logic                         s1_op;
  logic [KEY_BITS-1:0]          s1_key;
  logic [frsr_pkg::LEN_W-1:0]   s1_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_op  <= op;
      s1_key <= key_in;
      s1_len <= pkt_len;
    end
  end

  // key match and slot choice; a new key takes the next free slot here,
  // so the following item already sees it
  logic              s1_hit;
  logic              s1_insert;
  logic [SLOT_W-1:0] s1_slot;

  frsr_cam #(
    .FLOWS    (FLOWS),
    .KEY_BITS (KEY_BITS)
  ) u_cam (
    .clk       (clk),
    .rst       (rst),
    .lookup_en (s1_valid),
    .op        (s1_op),
    .key       (s1_key),
    .hit       (s1_hit),
    .insert    (s1_insert),
    .slot      (s1_slot)
  );

  // update stage registers
  frsr_pkg::lookup_t            s2_ctl;
  logic [frsr_pkg::LEN_W-1:0]   s2_len;
  logic [SLOT_W-1:0]            s2_slot;
  logic                         s2_byp;
  logic [frsr_pkg::COUNT_W-1:0] s2_byp_data;
  logic [frsr_pkg::COUNT_W-1:0] rd_data;
  logic [frsr_pkg::COUNT_W-1:0] cur;

  logic                         wr_en;
  logic [frsr_pkg::COUNT_W-1:0] new_count;
  logic [frsr_pkg::COUNT_W-1:0] prio;
  frsr_pkg::status_t            st;

  frsr_count_mem #(
    .FLOWS (FLOWS)
  ) u_mem (
    .clk     (clk),
    .rd_addr (s1_slot),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s2_slot),
    .wr_data (new_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else begin
      s2_ctl.valid  <= s1_valid;
      s2_ctl.op     <= s1_op;
      s2_ctl.hit    <= s1_hit;
      s2_ctl.insert <= s1_insert;
    end
  end

  // memory read races the write of the item ahead: keep the fresh count
  always_ff @(posedge clk) begin
    s2_len      <= s1_len;
    s2_slot     <= s1_slot;
    s2_byp      <= wr_en && (s2_slot == s1_slot);
    s2_byp_data <= new_count;
  end

  assign cur = s2_byp ? s2_byp_data : rd_data;

  frsr_update u_update (
    .ctl       (s2_ctl),
    .len       (s2_len),
    .cur       (cur),
    .we        (wr_en),
    .new_count (new_count),
    .prio      (prio),
    .status    (st)
  );

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    priority_res <= prio;
    status       <= 2'(st);
  end

endmodule

`default_nettype wire
